[rtl/oblc_pkg.sv]
// Types, opcodes and sizing for the order book level CAM.
// No dependencies; every other file in rtl imports this package.
package oblc_pkg;

    localparam int LEVEL_COUNT   = 16;
    localparam int QUANTITY_BITS = 24;
    localparam int PRICE_BITS    = 32;
    localparam int COUNT_BITS    = 5;

    localparam int SLOT_W      = $clog2(LEVEL_COUNT);
    localparam int CNT_W       = $clog2(LEVEL_COUNT + 1);
    localparam int TREE_DEPTH  = $clog2(LEVEL_COUNT);
    localparam int TREE_LEAVES = 1 << TREE_DEPTH;

    localparam logic [1:0] OP_ADD   = 2'd0;
    localparam logic [1:0] OP_SUB   = 2'd1;
    localparam logic [1:0] OP_SET   = 2'd2;
    localparam logic [1:0] OP_CLEAR = 2'd3;

    localparam logic BID_SIDE = 1'b0;
    localparam logic ASK_SIDE = 1'b1;

    typedef logic [QUANTITY_BITS-1:0] t_qty;
    typedef logic [PRICE_BITS-1:0]    t_price;

    typedef struct packed {
        logic [1:0] op;
        logic       book_side;
        t_price     level_price;
        t_qty       quantity;
    } t_in_item;

    typedef struct packed {
        logic                  bid_present;
        t_price                best_bid_price;
        t_qty                  best_bid_quantity;
        logic                  ask_present;
        t_price                best_ask_price;
        t_qty                  best_ask_quantity;
        logic                  overflowed;
        logic [COUNT_BITS-1:0] active_levels;
    } t_out_item;

    typedef struct packed {
        logic load;
        logic update;
        logic emit;
    } t_ctl_cmd;

    typedef struct packed {
        logic   present;
        t_price price;
        t_qty   qty;
    } t_node;

    // Left wins ties so the lower slot is kept, as a linear scan would.
    function automatic t_node pick_bid(input t_node a, input t_node b);
        if (a.present && (!b.present || a.price >= b.price)) begin
            return a;
        end
        return b;
    endfunction

    function automatic t_node pick_ask(input t_node a, input t_node b);
        if (a.present && (!b.present || a.price <= b.price)) begin
            return a;
        end
        return b;
    endfunction

endpackage

[rtl/oblc_ctrl.sv]
// Sequencer for the order book level CAM: accept, update, reduce, report.
// Depends on oblc_pkg.
module oblc_ctrl (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                start,
    output logic                busy,
    output oblc_pkg::t_ctl_cmd  o_cmd
);
    import oblc_pkg::*;

    localparam int REDUCE_CYCLES = TREE_DEPTH + 1;
    localparam int RC_W          = $clog2(REDUCE_CYCLES);

    localparam logic [1:0] S_IDLE   = 2'd0;
    localparam logic [1:0] S_UPDATE = 2'd1;
    localparam logic [1:0] S_REDUCE = 2'd2;

    logic [1:0]      r_state, n_state;
    logic [RC_W-1:0] r_cnt, n_cnt;
    logic            w_last;

    assign busy   = (r_state != S_IDLE);
    assign w_last = (r_cnt == RC_W'(REDUCE_CYCLES - 1));

    always_comb begin
        n_state      = r_state;
        n_cnt        = r_cnt;
        o_cmd.load   = 1'b0;
        o_cmd.update = 1'b0;
        o_cmd.emit   = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                if (start) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_UPDATE;
                end
            end
            S_UPDATE: begin
                o_cmd.update = 1'b1;
                n_cnt        = '0;
                n_state      = S_REDUCE;
            end
            S_REDUCE: begin
                // wait here while the root of the tree settles after the update
                if (w_last) begin
                    o_cmd.emit = 1'b1;
                    n_state    = S_IDLE;
                end else begin
                    n_cnt = r_cnt + 1'b1;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
        end
    end

endmodule

[rtl/oblc_datapath.sv]
// Level store, match/allocate logic and registered best-price tree.
// Depends on oblc_pkg; driven by commands from oblc_ctrl.
module oblc_datapath (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  oblc_pkg::t_ctl_cmd  i_cmd,
    input  oblc_pkg::t_in_item  i_item,
    output oblc_pkg::t_out_item o_result,
    output logic                o_result_valid
);
    import oblc_pkg::*;

    t_in_item r_item;

    logic   r_valid [LEVEL_COUNT];
    logic   r_side  [LEVEL_COUNT];
    t_price r_price [LEVEL_COUNT];
    t_qty   r_qty   [LEVEL_COUNT];
    logic   r_overflow;

    logic              w_hit, w_free;
    logic [SLOT_W-1:0] w_hit_idx, w_free_idx;
    t_qty              w_cur_qty, w_new_qty;
    logic              w_want_alloc;
    logic              w_wr_hit, w_wr_alloc, w_set_ovf;

    t_node w_bid [1:2*TREE_LEAVES-1];
    t_node w_ask [1:2*TREE_LEAVES-1];
    t_node r_bid [1:TREE_LEAVES-1];
    t_node r_ask [1:TREE_LEAVES-1];

    logic [CNT_W-1:0] w_count, r_count;

    t_out_item r_out;
    logic      r_out_valid;

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_item <= i_item;
        end
    end

    // Match and first-free search; scan downwards so the lowest slot wins.
    always_comb begin
        w_hit      = 1'b0;
        w_hit_idx  = '0;
        w_free     = 1'b0;
        w_free_idx = '0;
        for (int i = LEVEL_COUNT - 1; i >= 0; i--) begin
            if (r_valid[i] && r_side[i] == r_item.book_side
                    && r_price[i] == r_item.level_price) begin
                w_hit     = 1'b1;
                w_hit_idx = SLOT_W'(i);
            end
            if (!r_valid[i]) begin
                w_free     = 1'b1;
                w_free_idx = SLOT_W'(i);
            end
        end
    end

    assign w_cur_qty = r_qty[w_hit_idx];

    always_comb begin
        unique case (r_item.op)
            OP_ADD:   w_new_qty = w_cur_qty + r_item.quantity;
            OP_SUB:   w_new_qty = (w_cur_qty > r_item.quantity) ?
                                  (w_cur_qty - r_item.quantity) : '0;
            OP_SET:   w_new_qty = r_item.quantity;
            OP_CLEAR: w_new_qty = '0;
            default:  w_new_qty = '0;
        endcase
    end

    assign w_want_alloc = (r_item.op == OP_ADD || r_item.op == OP_SET)
                          && (r_item.quantity != '0);
    assign w_wr_hit     = i_cmd.update && w_hit;
    assign w_wr_alloc   = i_cmd.update && !w_hit && w_want_alloc && w_free;
    assign w_set_ovf    = i_cmd.update && !w_hit && w_want_alloc && !w_free;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < LEVEL_COUNT; i++) begin
                r_valid[i] <= 1'b0;
            end
            r_overflow <= 1'b0;
        end else begin
            if (w_wr_hit && w_new_qty == '0) begin
                r_valid[w_hit_idx] <= 1'b0;
            end
            if (w_wr_alloc) begin
                r_valid[w_free_idx] <= 1'b1;
            end
            if (w_set_ovf) begin
                r_overflow <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_wr_hit) begin
            r_qty[w_hit_idx] <= w_new_qty;
        end
        if (w_wr_alloc) begin
            r_side[w_free_idx]  <= r_item.book_side;
            r_price[w_free_idx] <= r_item.level_price;
            r_qty[w_free_idx]   <= r_item.quantity;
        end
    end

    // Leaves come straight from the store; padding leaves are empty.
    always_comb begin
        for (int j = 0; j < TREE_LEAVES; j++) begin
            w_bid[TREE_LEAVES + j] = '0;
            w_ask[TREE_LEAVES + j] = '0;
            if (j < LEVEL_COUNT) begin
                if (r_valid[j] && r_side[j] == BID_SIDE) begin
                    w_bid[TREE_LEAVES + j] = '{present: 1'b1, price: r_price[j],
                                               qty: r_qty[j]};
                end
                if (r_valid[j] && r_side[j] == ASK_SIDE) begin
                    w_ask[TREE_LEAVES + j] = '{present: 1'b1, price: r_price[j],
                                               qty: r_qty[j]};
                end
            end
        end
        for (int i = 1; i < TREE_LEAVES; i++) begin
            w_bid[i] = r_bid[i];
            w_ask[i] = r_ask[i];
        end
    end

    // One compare per level between registers.
    always_ff @(posedge i_clk) begin
        for (int i = 1; i < TREE_LEAVES; i++) begin
            r_bid[i] <= pick_bid(w_bid[2*i], w_bid[2*i + 1]);
            r_ask[i] <= pick_ask(w_ask[2*i], w_ask[2*i + 1]);
        end
    end

    always_comb begin
        w_count = '0;
        for (int i = 0; i < LEVEL_COUNT; i++) begin
            w_count = w_count + CNT_W'(r_valid[i]);
        end
    end

    always_ff @(posedge i_clk) begin
        r_count <= w_count;
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            r_out.bid_present       <= w_bid[1].present;
            r_out.best_bid_price    <= w_bid[1].price;
            r_out.best_bid_quantity <= w_bid[1].qty;
            r_out.ask_present       <= w_ask[1].present;
            r_out.best_ask_price    <= w_ask[1].price;
            r_out.best_ask_quantity <= w_ask[1].qty;
            r_out.overflowed        <= r_overflow;
            r_out.active_levels     <= COUNT_BITS'(r_count);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= i_cmd.emit;
        end
    end

    assign o_result       = r_out;
    assign o_result_valid = r_out_valid;

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(LEVEL_COUNT))
        else $error("level count above pool size");

    a_ovf_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_overflow |=> r_overflow)
        else $error("overflow flag dropped without reset");

    a_one_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $countones({w_wr_hit, w_wr_alloc, w_set_ovf}) <= 1)
        else $error("update took more than one action");
`endif

endmodule

[rtl/order_book_level_cam_unit.sv]
// Order book level CAM, top level: sequencer plus level store and best-price tree.
// Depends on oblc_pkg, oblc_ctrl and oblc_datapath.
//
// Each update is taken when start is high and busy is low, and yields exactly
// one result: the level store is matched and written first, then the best
// prices climb the levels of the registered best-price tree, and the root is
// captured into the result register; the tree depth, log2 of the level count,
// sets the length of that span. busy stays high for that whole span and drops
// as the result appears; the next update is taken at the edge that ends the
// result cycle, so no update is accepted before the last one's result shows.
// The result is shown for a single cycle with o_result_valid and cannot be
// stalled. The store is empty after reset, with no clearing pass.
module order_book_level_cam_unit (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                start,
    input  oblc_pkg::t_in_item  i_item,
    output logic                busy,
    output oblc_pkg::t_out_item o_result,
    output logic                o_result_valid
);
    import oblc_pkg::*;

    t_ctl_cmd w_cmd;

    oblc_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .busy    (busy),
        .o_cmd   (w_cmd)
    );

    oblc_datapath u_datapath (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (w_cmd),
        .i_item         (i_item),
        .o_result       (o_result),
        .o_result_valid (o_result_valid)
    );

`ifndef SYNTHESIS
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("transfer accepted but block not busy");

    a_result_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_valid |-> !busy)
        else $error("result shown while still busy");

    a_result_pulse: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_valid |=> !o_result_valid)
        else $error("result strobe longer than one cycle");

    a_count_sides: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_valid |-> ((o_result.bid_present || o_result.ask_present)
                            == (o_result.active_levels != '0)))
        else $error("active count disagrees with present flags");
`endif

endmodule
